FILE: src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, off during reset.
`define ASSERT_IMP(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

FILE: src/efd_pkg.sv
// Package: types and constants of the subset builder.
`default_nettype none
package efd_pkg;
  localparam int unsigned MaskW = 16;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned SrcW  = 4;

  localparam logic [1:0] RegCount  = 2'd0;
  localparam logic [1:0] RegStart  = 2'd1;
  localparam logic [1:0] RegAccept = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StClInit, StClStep, StStart, StRowRd, StMove, StSrch, StSrchRd, StOut
  } state_e;

  typedef struct packed {
    logic [SrcW-1:0]  source_state;
    logic [MaskW-1:0] next_on_zero_set;
    logic [MaskW-1:0] next_on_one_set;
    logic [MaskW-1:0] epsilon_set;
    logic             last_state;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]  dfa_index;
    logic [MaskW-1:0] subset_mask;
    logic [IdxW-1:0]  dfa_next_zero;
    logic [IdxW-1:0]  dfa_next_one;
    logic             accepting;
    logic             overflow;
    logic             last_row;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;
endpackage
`default_nettype wire

FILE: src/efd_if.sv
// Valid/ready stream interface carrying one payload type.
`default_nettype none
interface efd_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/efd_mover.sv
// Shared set-image unit: takes one NFA state per cycle while step_i is high, ORs its image in when bit_i is set.
`default_nettype none
module efd_mover import efd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             clear_i,
  input  wire logic             step_i,
  input  wire logic             bit_i,
  input  wire logic [MaskW-1:0] image_i,
  output logic      [MaskW-1:0] acc_o
);
  logic [MaskW-1:0] acc_q, acc_d;
  always_comb begin
    acc_d = acc_q;
    if (clear_i) acc_d = '0;
    else if (step_i && bit_i) acc_d = acc_q | image_i;
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end
  assign acc_o = acc_q;
endmodule
`default_nettype wire

FILE: src/enfa_to_dfa_subset_builder.sv
// Top level: epsilon-NFA to DFA subset construction engine.
// Usage:
//  - cfg channel: beat writes register index (0 count, 1 start, 2 accept mask).
//  - in channel: one beat per NFA state loads its symbol-0/1 and epsilon masks.
//    A beat with last_state set starts a run; ready stays low until the final
//    row of the run has been taken.
//  - out channel: one beat per DFA state in discovery order, last_row on the
//    final one; overflow flags a full table and ends the run.
// Sequencing: the closure of each NFA state is built in at most n+1 passes
//  (n = active states), each pass scanning one state per cycle in the shared
//  OR unit; a start step follows. Each DFA row then takes a read step, then
//  per symbol the move steps (image phase, then closure phase) and a search
//  of the subsets found so far, one table entry at a time through the single
//  read port, and finally an output step.
// Reset: registers return to count 1, start 0, accept mask 0; tables hold
//  garbage until loaded. A stalled receiver holds the row in the output
//  register; the engine waits there, nothing is lost.
`default_nettype none
module enfa_to_dfa_subset_builder import efd_pkg::*; #(
  parameter int unsigned MAX_NFA_STATES = 16,
  parameter int unsigned MAX_DFA_STATES = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  efd_if.sink       cfg,
  efd_if.sink       in_ch,
  efd_if.source     out_ch
);
`include "assert_macros.svh"
  localparam int unsigned NS  = (MAX_NFA_STATES < 16) ? MAX_NFA_STATES : 16;
  localparam int unsigned NW  = $clog2(MAX_NFA_STATES);
  localparam int unsigned DW  = $clog2(MAX_DFA_STATES);
  localparam int unsigned CW  = DW + 1;

  logic [MaskW-1:0] zero_mem [MAX_NFA_STATES];
  logic [MaskW-1:0] one_mem  [MAX_NFA_STATES];
  logic [MaskW-1:0] eps_mem  [MAX_NFA_STATES];
  logic [MaskW-1:0] clo_mem  [MAX_NFA_STATES];
  logic [MaskW-1:0] sub_mem  [MAX_DFA_STATES];

  logic [4:0]  cnt_q;
  logic [3:0]  start_q;
  logic [15:0] acc_q;

  state_e st_q, st_d;
  logic [4:0]   i_q, i_d;       // state being closed / scan index j
  logic [4:0]   j_q, j_d;
  logic [4:0]   it_q, it_d;
  logic [MaskW-1:0] c_q, c_d;    // current closure / phase-0 image, then its closure
  logic         sym_q, sym_d;    // 0 or 1 symbol; phase for move (0 image, 1 close)
  logic         ph_q, ph_d;
  logic [MaskW-1:0] cur_q, cur_d;
  logic [CW-1:0] cntd_q, cntd_d;  // subset_count
  logic [CW-1:0] wp_q, wp_d;
  logic [CW-1:0] k_q, k_d;
  logic [MaskW-1:0] rd_q;
  logic [IdxW-1:0] nz_q, nz_d, no_q, no_d;
  logic         ovf_q, ovf_d;
  out_item_t    ob_q, ob_d;
  logic         ov_q, ov_d;

  // active count and valid mask
  logic [4:0] n;
  logic [MaskW-1:0] vmask;
  always_comb begin
    n = cnt_q;
    if (n == 5'd0) n = 5'd1;
    if (n > 5'(NS)) n = 5'(NS);
    vmask = MaskW'((17'd1 << n) - 17'd1);
  end

  // shared OR unit
  logic mv_clear, mv_step, mv_bit;
  logic [MaskW-1:0] mv_img, mv_acc;
  efd_mover u_mover (
    .clk_i, .clear_i(mv_clear), .step_i(mv_step), .bit_i(mv_bit),
    .image_i(mv_img), .acc_o(mv_acc)
  );

  logic [NW-1:0] ja;
  assign ja = NW'(j_q);
  logic in_acc, cfg_acc, out_acc;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg.valid && cfg.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign cfg.ready = 1'b1;
  assign in_ch.ready = (st_q == StIdle) && !ov_q;
  assign out_ch.valid = ov_q;
  assign out_ch.data = ob_q;

  // move image source for a scan step
  always_comb begin
    mv_img = '0;
    if (st_q == StClStep) mv_img = eps_mem[ja] & vmask;
    else if (st_q == StMove) begin
      if (!ph_q) mv_img = (sym_q ? one_mem[ja] : zero_mem[ja]) & vmask;
      else mv_img = clo_mem[ja];
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:   if (in_acc && in_ch.data.last_state) st_d = StClInit;
      StClInit: st_d = StClStep;
      StClStep: if (j_q == n) begin
          if ((mv_acc | c_q) == c_q || it_q == n) begin
            if (i_q + 5'd1 == n) st_d = StStart; else st_d = StClInit;
          end else st_d = StClStep;
        end
      StStart:  st_d = StRowRd;
      StRowRd:  st_d = StMove;
      StMove:   if (j_q == n && ph_q) st_d = StSrch;
      StSrch:   st_d = (k_q == cntd_q) ? StSrch : StSrchRd;
      StSrchRd: st_d = StSrch;
      StOut:    if (!ov_q || out_acc)
                  st_d = (ovf_q || (wp_q + CW'(1) >= cntd_q)) ? StIdle : StRowRd;
      default:  st_d = StIdle;
    endcase
    if (st_q == StSrch && k_q == cntd_q) begin
      if (cntd_q < CW'(MAX_DFA_STATES) && !sym_q) st_d = StMove;
      else if (cntd_q < CW'(MAX_DFA_STATES)) st_d = StOut;
      else st_d = StOut;
    end
    if (st_q == StSrchRd && rd_q == c_q) st_d = sym_q ? StOut : StMove;
  end

  // datapath updates
  always_comb begin
    i_d = i_q; j_d = j_q; it_d = it_q; c_d = c_q; sym_d = sym_q; ph_d = ph_q;
    cur_d = cur_q; cntd_d = cntd_q; wp_d = wp_q; k_d = k_q;
    nz_d = nz_q; no_d = no_q; ovf_d = ovf_q; ob_d = ob_q; ov_d = ov_q;
    mv_clear = 1'b0; mv_step = 1'b0; mv_bit = 1'b0;
    if (out_acc) ov_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        i_d = '0;
      end
      StClInit: begin
        c_d = MaskW'(17'd1 << i_q); j_d = '0; it_d = '0;
        mv_clear = 1'b1;
      end
      StClStep: begin
        if (j_q == n) begin
          // one closure pass finished: acc holds image of c; add c
          j_d = '0; mv_clear = 1'b1;
          if ((mv_acc | c_q) == c_q || it_q == n) begin
            i_d = i_q + 5'd1;
          end else begin
            c_d = mv_acc | c_q; it_d = it_q + 5'd1;
          end
        end else begin
          mv_step = 1'b1; mv_bit = c_q[j_q[3:0]]; j_d = j_q + 5'd1;
        end
      end
      StStart: begin
        cntd_d = CW'(1); wp_d = '0;
      end
      StRowRd: begin
        sym_d = 1'b0; ph_d = 1'b0; j_d = '0; mv_clear = 1'b1;
        nz_d = '0; no_d = '0; ovf_d = 1'b0;
      end
      StMove: begin
        if (j_q == n) begin
          j_d = '0; mv_clear = 1'b1;
          if (!ph_q) begin ph_d = 1'b1; c_d = mv_acc; end
          else begin c_d = mv_acc; k_d = '0; end
        end else begin
          mv_step = 1'b1;
          mv_bit = ph_q ? c_q[j_q[3:0]] : cur_q[j_q[3:0]];
          j_d = j_q + 5'd1;
        end
      end
      StSrch: begin
        if (k_q == cntd_q) begin
          if (cntd_q < CW'(MAX_DFA_STATES)) begin
            if (!sym_q) nz_d = IdxW'(cntd_q); else no_d = IdxW'(cntd_q);
            cntd_d = cntd_q + CW'(1);
          end else begin
            // symbol-1 overflow keeps the resolved symbol-0 index
            ovf_d = 1'b1; no_d = '0;
          end
          sym_d = 1'b1; ph_d = 1'b0; j_d = '0; mv_clear = 1'b1;
        end
      end
      StSrchRd: begin
        if (rd_q == c_q) begin
          if (!sym_q) nz_d = IdxW'(k_q); else no_d = IdxW'(k_q);
          sym_d = 1'b1; ph_d = 1'b0; j_d = '0; mv_clear = 1'b1;
        end else k_d = k_q + CW'(1);
      end
      StOut: begin
        if (!ov_q || out_acc) begin
          ov_d = 1'b1;
          ob_d.dfa_index = IdxW'(wp_q); ob_d.subset_mask = cur_q;
          ob_d.dfa_next_zero = nz_q;
          ob_d.dfa_next_one = ovf_q ? '0 : no_q;
          ob_d.accepting = |(cur_q & acc_q & vmask);
          ob_d.overflow = ovf_q;
          ob_d.last_row = ovf_q || (wp_q + CW'(1) >= cntd_q);
          wp_d = wp_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // when symbol-0 overflow, skip symbol 1: handled by StSrch routing to StOut
  always_ff @(posedge clk_i) begin
    if (in_acc && (32'(in_ch.data.source_state) < MAX_NFA_STATES)) begin
      zero_mem[NW'(in_ch.data.source_state)] <= in_ch.data.next_on_zero_set;
      one_mem[NW'(in_ch.data.source_state)]  <= in_ch.data.next_on_one_set;
      eps_mem[NW'(in_ch.data.source_state)]  <= in_ch.data.epsilon_set;
    end
    if (st_q == StClStep && j_q == n && ((mv_acc | c_q) == c_q || it_q == n))
      clo_mem[NW'(i_q)] <= c_q;
    if (st_q == StStart)
      sub_mem[0] <= (32'(start_q) < 32'(n)) ? clo_mem[NW'(start_q)] : '0;
    if (st_q == StSrch && k_q == cntd_q && cntd_q < CW'(MAX_DFA_STATES))
      sub_mem[DW'(cntd_q)] <= c_q;
    if (st_q == StSrch) rd_q <= sub_mem[DW'(k_q)];
    if (st_q == StRowRd) cur_q <= sub_mem[DW'(wp_q)];
    ob_q <= ob_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ov_q <= 1'b0;
      cnt_q <= 5'd1; start_q <= '0; acc_q <= '0;
      i_q <= '0; j_q <= '0; it_q <= '0; c_q <= '0; sym_q <= 1'b0; ph_q <= 1'b0;
      cntd_q <= '0; wp_q <= '0; k_q <= '0;
      nz_q <= '0; no_q <= '0; ovf_q <= 1'b0;
    end else begin
      st_q <= (st_q == StSrch && k_q == cntd_q && ovf_d) ? StOut : st_d;
      ov_q <= ov_d;
      i_q <= i_d; j_q <= j_d; it_q <= it_d; c_q <= c_d; sym_q <= sym_d; ph_q <= ph_d;
      cntd_q <= cntd_d; wp_q <= wp_d; k_q <= k_d;
      nz_q <= nz_d; no_q <= no_d; ovf_q <= ovf_d;
      if (cfg_acc) begin
        unique case (cfg.data.index)
          RegCount:  cnt_q <= cfg.data.data[4:0];
          RegStart:  start_q <= cfg.data.data[3:0];
          RegAccept: acc_q <= cfg.data.data[15:0];
          default: ;
        endcase
      end
    end
  end

  `ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, st_q != StIdle, !in_ch.ready, "ready while busy")
  `ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, cntd_q <= CW'(MAX_DFA_STATES), "count overflow")
  `ASSERT_NXT(a_hold, clk_i, rst_ni, out_ch.valid && !out_ch.ready, out_ch.valid, "row dropped")
endmodule
`default_nettype wire
